// ===== hdl/tsem_pkg.sv =====
package tsem_pkg;

  localparam int SENSORS = 16;
  localparam int IDX_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int LIM_W   = 9;
  localparam logic [LIM_W-1:0] SENSORS_LIM = LIM_W'(SENSORS);

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SET    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE    = 2'd0;
  localparam logic [1:0] REG_HYST_UP   = 2'd1;
  localparam logic [1:0] REG_HYST_DOWN = 2'd2;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  localparam logic [3:0] CODE_NONE  = 4'd0;
  localparam logic [3:0] EV_LNR_GL  = 4'd0;
  localparam logic [3:0] EV_LNR_GH  = 4'd1;
  localparam logic [3:0] EV_LC_GL   = 4'd2;
  localparam logic [3:0] EV_LC_GH   = 4'd3;
  localparam logic [3:0] EV_LNC_GL  = 4'd4;
  localparam logic [3:0] EV_LNC_GH  = 4'd5;
  localparam logic [3:0] EV_UNC_GL  = 4'd6;
  localparam logic [3:0] EV_UNC_GH  = 4'd7;
  localparam logic [3:0] EV_UC_GL   = 4'd8;
  localparam logic [3:0] EV_UC_GH   = 4'd9;
  localparam logic [3:0] EV_UNR_GL  = 4'd10;
  localparam logic [3:0] EV_UNR_GH  = 4'd11;

  localparam logic [2:0] LVL_LNR    = 3'd0;
  localparam logic [2:0] LVL_LCR    = 3'd1;
  localparam logic [2:0] LVL_LNC    = 3'd2;
  localparam logic [2:0] LVL_NORMAL = 3'd3;
  localparam logic [2:0] LVL_UNC    = 3'd4;
  localparam logic [2:0] LVL_UCR    = 3'd5;
  localparam logic [2:0] LVL_UNR    = 3'd6;

  // threshold byte positions in a row, same order as the write mask bits
  localparam int TH_LNC = 0;
  localparam int TH_LCR = 1;
  localparam int TH_LNR = 2;
  localparam int TH_UNC = 3;
  localparam int TH_UCR = 4;
  localparam int TH_UNR = 5;
  localparam int TH_N   = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEND0,
    ST_SEND1
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic sel_second;
  } cmd_t;

  typedef struct packed {
    logic no_result;
    logic first_last;
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] code;
    logic [2:0] level;
    logic       last;
  } result_t;

endpackage

// ===== hdl/threshold_sensor_event_monitor.sv =====
// per-sensor threshold monitor with hysteresis, one request at a time
// accept / row read / evaluate / send sequence around the single-port threshold memory:
// the eval state registers up to two results and the send states offer them; a quiet sample
// sends none, and a new request is taken only after the last result is taken
// reset (synchronous, rst high): all sensor levels normal, active_sensors 16, hysteresis 0
module threshold_sensor_event_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  sensor,
  input  logic [7:0]  sample_value,
  input  logic [5:0]  write_mask,
  input  logic [7:0]  lower_noncrit,
  input  logic [7:0]  lower_crit,
  input  logic [7:0]  lower_nonrec,
  input  logic [7:0]  upper_noncrit,
  input  logic [7:0]  upper_crit,
  input  logic [7:0]  upper_nonrec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  event_sensor,
  output logic [3:0]  event_code,
  output logic [2:0]  level_after,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] active_sensors;
  logic [7:0] hyst_up;
  logic [7:0] hyst_down;
  logic [1:0] reg_idx;

  tsem_pkg::cmd_t    cmd;
  tsem_pkg::status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sensors <= 5'd16;
      hyst_up        <= 8'd0;
      hyst_down      <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        tsem_pkg::REG_ACTIVE:    active_sensors <= pwdata[4:0];
        tsem_pkg::REG_HYST_UP:   hyst_up        <= pwdata[7:0];
        tsem_pkg::REG_HYST_DOWN: hyst_down      <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tsem_pkg::REG_ACTIVE:    prdata = {27'd0, active_sensors};
      tsem_pkg::REG_HYST_UP:   prdata = {24'd0, hyst_up};
      tsem_pkg::REG_HYST_DOWN: prdata = {24'd0, hyst_down};
      default:                 prdata = 32'd0;
    endcase
  end

  tsem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tsem_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req_type),
    .sensor         (sensor),
    .sample_value   (sample_value),
    .write_mask     (write_mask),
    .lower_noncrit  (lower_noncrit),
    .lower_crit     (lower_crit),
    .lower_nonrec   (lower_nonrec),
    .upper_noncrit  (upper_noncrit),
    .upper_crit     (upper_crit),
    .upper_nonrec   (upper_nonrec),
    .active_sensors (active_sensors),
    .hyst_up        (hyst_up),
    .hyst_down      (hyst_down),
    .kind           (kind),
    .event_sensor   (event_sensor),
    .event_code     (event_code),
    .level_after    (level_after),
    .last           (last)
  );

endmodule

// ===== hdl/tsem_ctrl.sv =====
module tsem_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tsem_pkg::status_t status,
  output tsem_pkg::cmd_t    cmd
);

  tsem_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.capture    = 1'b0;
    cmd.eval       = 1'b0;
    cmd.sel_second = 1'b0;
    case (state)
      tsem_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = tsem_pkg::ST_EVAL;
      end
      tsem_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        // quiet sample produces nothing
        state_next = status.no_result ? tsem_pkg::ST_IDLE : tsem_pkg::ST_SEND0;
      end
      tsem_pkg::ST_SEND0: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.first_last ? tsem_pkg::ST_IDLE : tsem_pkg::ST_SEND1;
        end
      end
      tsem_pkg::ST_SEND1: begin
        out_valid      = 1'b1;
        cmd.sel_second = 1'b1;
        if (out_ready) state_next = tsem_pkg::ST_IDLE;
      end
      default: begin
        state_next = tsem_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tsem_dp.sv =====
module tsem_dp (
  input  logic              clk,
  input  logic              rst,
  input  tsem_pkg::cmd_t    cmd,
  output tsem_pkg::status_t status,
  input  logic              req_type,
  input  logic [7:0]        sensor,
  input  logic [7:0]        sample_value,
  input  logic [5:0]        write_mask,
  input  logic [7:0]        lower_noncrit,
  input  logic [7:0]        lower_crit,
  input  logic [7:0]        lower_nonrec,
  input  logic [7:0]        upper_noncrit,
  input  logic [7:0]        upper_crit,
  input  logic [7:0]        upper_nonrec,
  input  logic [4:0]        active_sensors,
  input  logic [7:0]        hyst_up,
  input  logic [7:0]        hyst_down,
  output logic [1:0]        kind,
  output logic [7:0]        event_sensor,
  output logic [3:0]        event_code,
  output logic [2:0]        level_after,
  output logic              last
);

  logic [7:0] thr_mem [tsem_pkg::SENSORS][tsem_pkg::TH_N];
  logic [7:0] thr_rd  [tsem_pkg::TH_N];
  logic [7:0] wdata   [tsem_pkg::TH_N];
  logic [2:0] level   [tsem_pkg::SENSORS];

  logic       req_q;
  logic [7:0] sensor_q;
  logic [7:0] sample_q;
  logic [5:0] mask_q;
  logic [tsem_pkg::IDX_W-1:0] idx_q;

  tsem_pkg::result_t r0, r1, r0_next, r1_next, ev0, ev1, res;

  logic [tsem_pkg::LIM_W-1:0] limit;
  logic in_range;
  logic [2:0] lvl, lvl_new, t0, t1;
  logic [3:0] code0, code1;
  logic c0, c1;
  logic signed [9:0] v, lnr_u, lcr_u, lnc_u, unc_d, ucr_d, unr_d;
  logic signed [9:0] lnr, lcr, lnc, unc, ucr, unr;

  assign idx_q = sensor_q[tsem_pkg::IDX_W-1:0];

  // capture the request and read the threshold row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req_type;
      sensor_q <= sensor;
      sample_q <= sample_value;
      mask_q   <= write_mask;
      wdata[tsem_pkg::TH_LNC] <= lower_noncrit;
      wdata[tsem_pkg::TH_LCR] <= lower_crit;
      wdata[tsem_pkg::TH_LNR] <= lower_nonrec;
      wdata[tsem_pkg::TH_UNC] <= upper_noncrit;
      wdata[tsem_pkg::TH_UCR] <= upper_crit;
      wdata[tsem_pkg::TH_UNR] <= upper_nonrec;
      for (int i = 0; i < tsem_pkg::TH_N; i++) begin
        thr_rd[i] <= thr_mem[sensor[tsem_pkg::IDX_W-1:0]][i];
      end
    end
  end

  // byte-masked threshold write
  always_ff @(posedge clk) begin
    if (cmd.eval && in_range && req_q == tsem_pkg::REQ_SET) begin
      for (int i = 0; i < tsem_pkg::TH_N; i++) begin
        if (mask_q[i]) thr_mem[idx_q][i] <= wdata[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tsem_pkg::SENSORS; i++) begin
        level[i] <= tsem_pkg::LVL_NORMAL;
      end
    end else if (cmd.eval && in_range && req_q == tsem_pkg::REQ_SAMPLE) begin
      level[idx_q] <= lvl_new;
    end
  end

  always_comb begin
    if ({4'b0000, active_sensors} > tsem_pkg::SENSORS_LIM) begin
      limit = tsem_pkg::SENSORS_LIM;
    end else begin
      limit = {4'b0000, active_sensors};
    end
    in_range = {1'b0, sensor_q} < limit;
  end

  always_comb begin
    lvl = level[idx_q];
    v   = $signed({2'b00, sample_q});
    lnr = $signed({2'b00, thr_rd[tsem_pkg::TH_LNR]});
    lcr = $signed({2'b00, thr_rd[tsem_pkg::TH_LCR]});
    lnc = $signed({2'b00, thr_rd[tsem_pkg::TH_LNC]});
    unc = $signed({2'b00, thr_rd[tsem_pkg::TH_UNC]});
    ucr = $signed({2'b00, thr_rd[tsem_pkg::TH_UCR]});
    unr = $signed({2'b00, thr_rd[tsem_pkg::TH_UNR]});
    lnr_u = lnr + $signed({2'b00, hyst_up});
    lcr_u = lcr + $signed({2'b00, hyst_up});
    lnc_u = lnc + $signed({2'b00, hyst_up});
    unc_d = unc - $signed({2'b00, hyst_down});
    ucr_d = ucr - $signed({2'b00, hyst_down});
    unr_d = unr - $signed({2'b00, hyst_down});

    c0 = 1'b0;
    c1 = 1'b0;
    t0 = lvl;
    t1 = lvl;
    code0 = tsem_pkg::CODE_NONE;
    code1 = tsem_pkg::CODE_NONE;
    // both checks judged on the entry level
    case (lvl)
      tsem_pkg::LVL_LNR: begin
        c1 = v >= lnr_u; t1 = tsem_pkg::LVL_LCR; code1 = tsem_pkg::EV_LNR_GH;
      end
      tsem_pkg::LVL_LCR: begin
        c0 = v <= lnr;   t0 = tsem_pkg::LVL_LNR; code0 = tsem_pkg::EV_LNR_GL;
        c1 = v > lcr_u;  t1 = tsem_pkg::LVL_LNC; code1 = tsem_pkg::EV_LC_GH;
      end
      tsem_pkg::LVL_LNC: begin
        c0 = v <= lcr;   t0 = tsem_pkg::LVL_LCR;    code0 = tsem_pkg::EV_LC_GL;
        c1 = v > lnc_u;  t1 = tsem_pkg::LVL_NORMAL; code1 = tsem_pkg::EV_LNC_GH;
      end
      tsem_pkg::LVL_NORMAL: begin
        c0 = v <= lnc;   t0 = tsem_pkg::LVL_LNC; code0 = tsem_pkg::EV_LNC_GL;
        c1 = v >= unc;   t1 = tsem_pkg::LVL_UNC; code1 = tsem_pkg::EV_UNC_GH;
      end
      tsem_pkg::LVL_UNC: begin
        c0 = v >= ucr;   t0 = tsem_pkg::LVL_UCR;    code0 = tsem_pkg::EV_UC_GH;
        c1 = v < unc_d;  t1 = tsem_pkg::LVL_NORMAL; code1 = tsem_pkg::EV_UNC_GL;
      end
      tsem_pkg::LVL_UCR: begin
        c0 = v >= unr;   t0 = tsem_pkg::LVL_UNR; code0 = tsem_pkg::EV_UNR_GH;
        c1 = v < ucr_d;  t1 = tsem_pkg::LVL_UNC; code1 = tsem_pkg::EV_UC_GL;
      end
      tsem_pkg::LVL_UNR: begin
        c1 = v < unr_d;  t1 = tsem_pkg::LVL_UCR; code1 = tsem_pkg::EV_UNR_GL;
      end
      default: begin
        c0 = 1'b0;
      end
    endcase

    if (c1) begin
      lvl_new = t1;
    end else if (c0) begin
      lvl_new = t0;
    end else begin
      lvl_new = lvl;
    end

    ev0 = '{kind: tsem_pkg::KIND_EVENT, code: code0, level: t0, last: !c1};
    ev1 = '{kind: tsem_pkg::KIND_EVENT, code: code1, level: t1, last: 1'b1};

    r0_next = ev0;
    r1_next = ev1;
    status.no_result  = 1'b0;
    status.first_last = r0.last;
    if (!in_range) begin
      r0_next = '{kind: tsem_pkg::KIND_ERR, code: tsem_pkg::CODE_NONE,
                  level: tsem_pkg::LVL_LNR, last: 1'b1};
    end else if (req_q == tsem_pkg::REQ_SET) begin
      r0_next = '{kind: tsem_pkg::KIND_ACK, code: tsem_pkg::CODE_NONE,
                  level: lvl, last: 1'b1};
    end else if (!c0) begin
      // the first check did not hold: the second check's event moves to the front, and no result if neither held
      r0_next = ev1;
      status.no_result = !c1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      r0 <= r0_next;
      r1 <= r1_next;
    end
  end

  assign res          = cmd.sel_second ? r1 : r0;
  assign kind         = res.kind;
  assign event_sensor = sensor_q;
  assign event_code   = res.code;
  assign level_after  = res.level;
  assign last         = res.last;

endmodule
